// ----- hdl/vic_pkg.sv -----
// Shared types and constants for the tagged varint codec.
// No dependencies; compiled first.
package vic_pkg;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [1:0] TAG_1B = 2'd0;
    localparam logic [1:0] TAG_2B = 2'd1;
    localparam logic [1:0] TAG_4B = 2'd2;
    localparam logic [1:0] TAG_9B = 2'd3;

    localparam logic [63:0] LIM_1B = 64'h3f;
    localparam logic [63:0] LIM_2B = 64'h3fff;
    localparam logic [63:0] LIM_4B = 64'h3fff_ffff;

    localparam logic [7:0] LEAD_9B = 8'hc0;

    typedef logic [3:0] t_count;

    typedef struct packed {
        logic        done;
        logic [63:0] value;
        t_count      count;
    } t_dec_res;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        t_count     count;
    } t_enc_res;

    function automatic t_count len_of_tag(input logic [1:0] tag);
        t_count len;
        case (tag)
            TAG_1B:  len = 4'd1;
            TAG_2B:  len = 4'd2;
            TAG_4B:  len = 4'd4;
            default: len = 4'd9;
        endcase
        return len;
    endfunction

endpackage

// ----- hdl/vic_if.sv -----
// Channel interfaces for the tagged varint codec: input, result, config.
// Uses nothing beyond the language; compiled after vic_pkg.
interface vic_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [7:0]  in_byte;
    modport source (output valid, value, in_byte, input ready);
    modport sink   (input valid, value, in_byte, output ready);
endinterface

interface vic_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        last;
    logic [63:0] decoded_value;
    logic [3:0]  byte_count;
    modport source (output valid, out_byte, last, decoded_value, byte_count, input ready);
    modport sink   (input valid, out_byte, last, decoded_value, byte_count, output ready);
endinterface

interface vic_cfg_if;
    logic valid;
    logic ready;
    logic mode;
    modport source (output valid, mode, input ready);
    modport sink   (input valid, mode, output ready);
endinterface

// ----- hdl/vic_enc.sv -----
// Encoder byte select: tag, length and the byte at a given position.
// Depends on vic_pkg.
module vic_enc
    import vic_pkg::*;
(
    input  logic [63:0] i_value,
    input  logic [3:0]  i_idx,
    output t_enc_res    o_res
);
    logic [1:0] tag;
    t_count     total;
    t_count     pos;
    logic [7:0] vbyte;

    always_comb begin
        if (i_value > LIM_4B) begin
            tag = TAG_9B;
        end else if (i_value > LIM_2B) begin
            tag = TAG_4B;
        end else if (i_value > LIM_1B) begin
            tag = TAG_2B;
        end else begin
            tag = TAG_1B;
        end
        total = len_of_tag(tag);
        pos   = total - 4'd1 - i_idx;
        vbyte = i_value[{pos[2:0], 3'b000} +: 8];
        if (i_idx == 4'd0) begin
            if (tag == TAG_9B) begin
                o_res.out_byte = LEAD_9B;
            end else begin
                o_res.out_byte = {tag, vbyte[5:0]};
            end
        end else begin
            o_res.out_byte = vbyte;
        end
        o_res.last  = (i_idx == total - 4'd1);
        o_res.count = total;
    end
endmodule

// ----- hdl/vic_dec.sv -----
// Decoder state: accumulator, bytes seen and expected length.
// Depends on vic_pkg.
module vic_dec
    import vic_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_clear,
    output t_dec_res   o_res
);
    logic [63:0] r_acc, n_acc;
    t_count      r_seen, n_seen;
    t_count      r_exp, n_exp;

    always_comb begin
        if (r_exp == 4'd0) begin
            n_exp  = len_of_tag(i_byte[7:6]);
            n_acc  = (i_byte[7:6] == TAG_9B) ? 64'd0 : {58'd0, i_byte[5:0]};
            n_seen = 4'd1;
        end else begin
            n_exp  = r_exp;
            n_acc  = {r_acc[55:0], i_byte};
            n_seen = r_seen + 4'd1;
        end
        o_res.done  = (n_seen >= n_exp);
        o_res.count = n_exp;
        case (n_exp)
            4'd1:    o_res.value = n_acc & LIM_1B;
            4'd2:    o_res.value = n_acc & LIM_2B;
            4'd4:    o_res.value = n_acc & LIM_4B;
            default: o_res.value = n_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc  <= '0;
            r_seen <= '0;
            r_exp  <= '0;
        end else if (i_step) begin
            if (o_res.done) begin
                r_acc  <= '0;
                r_seen <= '0;
                r_exp  <= '0;
            end else begin
                r_acc  <= n_acc;
                r_seen <= n_seen;
                r_exp  <= n_exp;
            end
        end
    end
endmodule

// ----- hdl/tagged_varint_codec.sv -----
// Tagged varint codec, top level: input register, encoder/decoder, result register.
// Depends on vic_pkg, vic_if, vic_enc and vic_dec.
//
// Encodes a 64-bit value into 1, 2, 4 or 9 big-endian bytes (2-bit length tag in the
// first byte, 0xC0 lead for the 9-byte form) or, in decode mode, takes one byte per
// transaction and returns the value and its byte count when the last byte arrives.
// Encode emits one byte per cycle while the result register is free; the next value is
// taken in the cycle its last byte moves to the result register. Decode takes one byte
// every cycle unless a completing byte waits on a full result register. Results wait
// in a single result register; a new input is accepted while a result is pending.
// The user must write mode on the config channel only while idle; the block does not
// enforce it. A write also clears any partial decode.
module tagged_varint_codec
    import vic_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    vic_cfg_if.sink  i_cfg,
    vic_in_if.sink   i_in,
    vic_out_if.source o_out
);
    logic        r_mode;
    logic        r_a_valid;
    logic [63:0] r_a_value;
    logic [7:0]  r_a_byte;
    logic [3:0]  r_a_idx;

    logic        r_o_valid;
    logic [7:0]  r_o_byte;
    logic        r_o_last;
    logic [63:0] r_o_value;
    t_count      r_o_count;

    t_enc_res enc;
    t_dec_res dec;
    logic     is_enc;
    logic     b_free;
    logic     fire;
    logic     a_done;
    logic     in_acc;
    logic     cfg_acc;

    vic_enc u_enc (
        .i_value (r_a_value),
        .i_idx   (r_a_idx),
        .o_res   (enc)
    );

    vic_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (fire && !is_enc),
        .i_byte  (r_a_byte),
        .i_clear (cfg_acc),
        .o_res   (dec)
    );

    assign is_enc  = (r_mode == MODE_ENCODE);
    assign b_free  = !r_o_valid || o_out.ready;
    assign fire    = r_a_valid && (b_free || (!is_enc && !dec.done));
    assign a_done  = fire && (!is_enc || enc.last);
    assign i_in.ready = !r_a_valid || a_done;
    assign in_acc  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
        end else if (cfg_acc) begin
            r_mode <= i_cfg.mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_idx   <= '0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
            r_a_idx   <= '0;
        end else if (a_done) begin
            r_a_valid <= 1'b0;
        end else if (fire) begin
            r_a_idx <= r_a_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_value <= i_in.value;
            r_a_byte  <= i_in.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (fire && (is_enc || dec.done)) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && (is_enc || dec.done)) begin
            if (is_enc) begin
                r_o_byte  <= enc.out_byte;
                r_o_last  <= enc.last;
                r_o_value <= '0;
                r_o_count <= enc.count;
            end else begin
                r_o_byte  <= '0;
                r_o_last  <= 1'b0;
                r_o_value <= dec.value;
                r_o_count <= dec.count;
            end
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.out_byte      = r_o_byte;
    assign o_out.last          = r_o_last;
    assign o_out.decoded_value = r_o_value;
    assign o_out.byte_count    = r_o_count;
endmodule

// ----- hdl/vic_checker.sv -----
// Port-level checks for the tagged varint codec, bound to the top level.
// Depends on tagged_varint_codec and vic_if.
module vic_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_out_byte,
    input logic        i_out_last,
    input logic [63:0] i_out_value,
    input logic [3:0]  i_out_count
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable({i_out_byte, i_out_last, i_out_value,
                                                 i_out_count}))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_count == 4'd1 || i_out_count == 4'd2 ||
                         i_out_count == 4'd4 || i_out_count == 4'd9))
        else $error("illegal byte count");

    a_last_enc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> i_out_value == 64'd0)
        else $error("encoded byte carries a decoded value");
endmodule

bind tagged_varint_codec vic_checker u_vic_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last),
    .i_out_value (o_out.decoded_value),
    .i_out_count (o_out.byte_count)
);

// ----- dv/varint_checker.sv -----
// Scoreboard for the tagged varint codec: watches the config, input and result channels,
// predicts every result from its own copy of mode and decode state, and compares.
// Depends on vic_pkg and the channel interfaces in vic_if.
module varint_checker
    import vic_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    vic_cfg_if   cfg_ch,
    vic_in_if    in_ch,
    vic_out_if   out_ch,
    output int   o_pending,
    output int   o_errors
);

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last;
        logic [63:0] decoded_value;
        t_count      byte_count;
    } t_codec_result;

    t_codec_result predicted_q[$];

    logic        cur_mode;
    logic [63:0] dec_acc;
    t_count      dec_seen;
    t_count      dec_len;

    task automatic clear_decode();
        dec_acc  = '0;
        dec_seen = '0;
        dec_len  = '0;
    endtask

    task automatic encode_value(input logic [63:0] v);
        logic [1:0]    tag;
        int            nval;
        t_count        total;
        logic [7:0]    b;
        t_codec_result r;
        if (v > LIM_4B) begin
            tag = TAG_9B;
        end else if (v > LIM_2B) begin
            tag = TAG_4B;
        end else if (v > LIM_1B) begin
            tag = TAG_2B;
        end else begin
            tag = TAG_1B;
        end
        case (tag)
            TAG_1B:  nval = 1;
            TAG_2B:  nval = 2;
            TAG_4B:  nval = 4;
            default: nval = 8;
        endcase
        total = (tag == TAG_9B) ? 4'd9 : t_count'(nval);
        if (tag == TAG_9B) begin
            r = '{out_byte: LEAD_9B, last: 1'b0, decoded_value: '0, byte_count: total};
            predicted_q.push_back(r);
        end
        for (int i = 0; i < nval; i++) begin
            b = 8'(v >> ((nval - 1 - i) * 8));
            if (i == 0 && tag != TAG_9B) begin
                b = b | {tag, 6'd0};
            end
            r = '{out_byte: b, last: (i == nval - 1), decoded_value: '0, byte_count: total};
            predicted_q.push_back(r);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [63:0]   dv;
        t_codec_result r;
        if (dec_len == 0) begin
            case (b[7:6])
                TAG_1B:  dec_len = 4'd1;
                TAG_2B:  dec_len = 4'd2;
                TAG_4B:  dec_len = 4'd4;
                default: dec_len = 4'd9;
            endcase
            dec_acc  = (b[7:6] == TAG_9B) ? 64'd0 : {58'd0, b[5:0]};
            dec_seen = 4'd1;
        end else begin
            dec_acc  = {dec_acc[55:0], b};
            dec_seen = dec_seen + 4'd1;
        end
        if (dec_seen >= dec_len) begin
            case (dec_len)
                4'd1:    dv = dec_acc & LIM_1B;
                4'd2:    dv = dec_acc & LIM_2B;
                4'd4:    dv = dec_acc & LIM_4B;
                default: dv = dec_acc;
            endcase
            r = '{out_byte: 8'd0, last: 1'b0, decoded_value: dv, byte_count: dec_len};
            predicted_q.push_back(r);
            clear_decode();
        end
    endtask

    task automatic check_result();
        t_codec_result exp_r;
        if (predicted_q.size() == 0) begin
            $error("result with no expectation: out_byte %0h last %0b value %0h count %0d",
                   out_ch.out_byte, out_ch.last, out_ch.decoded_value, out_ch.byte_count);
            o_errors++;
        end else begin
            exp_r = predicted_q.pop_front();
            if (out_ch.out_byte !== exp_r.out_byte) begin
                $error("out_byte: expected %0h, actual %0h", exp_r.out_byte, out_ch.out_byte);
                o_errors++;
            end
            if (out_ch.last !== exp_r.last) begin
                $error("last: expected %0b, actual %0b", exp_r.last, out_ch.last);
                o_errors++;
            end
            if (out_ch.decoded_value !== exp_r.decoded_value) begin
                $error("decoded_value: expected %0h, actual %0h",
                       exp_r.decoded_value, out_ch.decoded_value);
                o_errors++;
            end
            if (out_ch.byte_count !== exp_r.byte_count) begin
                $error("byte_count: expected %0d, actual %0d",
                       exp_r.byte_count, out_ch.byte_count);
                o_errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mode = MODE_ENCODE;
            clear_decode();
            predicted_q.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                cur_mode = cfg_ch.mode;
                clear_decode();
            end
            if (in_ch.valid && in_ch.ready) begin
                if (cur_mode == MODE_ENCODE) begin
                    encode_value(in_ch.value);
                end else begin
                    decode_byte(in_ch.in_byte);
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                check_result();
            end
        end
        o_pending = predicted_q.size();
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top for tagged_varint_codec: clock, reset, mode writes, input and result
// traffic with random gaps and stalls; varint_checker does prediction and compare.
// Depends on vic_pkg, vic_if, the codec RTL and varint_checker.
module tb;
    import vic_pkg::*;

    localparam int MAX_CYCLES   = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 250;

    localparam logic [63:0] ENC_DIRECTED [9] = '{
        64'h0, 64'h3f, 64'h40, 64'h3fff, 64'h4000, 64'h3fff_ffff, 64'h4000_0000,
        64'hffff_ffff_ffff_ffff, 64'haaaa_aaaa_aaaa_aaaa
    };
    // tag 0, tag 1, tag 2 at max, tag 3 with nonzero lead low bits, then a partial value
    localparam logic [7:0] DEC_DIRECTED [18] = '{
        8'h3f, 8'h7f, 8'hff, 8'hbf, 8'hff, 8'hff, 8'hff,
        8'hff, 8'h5a, 8'ha5, 8'h00, 8'hff, 8'h01, 8'h80, 8'h7e, 8'hc3,
        8'h80, 8'h12
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;
    int   pending;
    int   errors;
    int   items_sent = 0;
    bit   no_gaps = 1'b0;
    bit   out_burst = 1'b0;

    vic_cfg_if cfg_ch();
    vic_in_if  in_ch();
    vic_out_if out_ch();

    tagged_varint_codec dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    varint_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .cfg_ch    (cfg_ch),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .o_pending (pending),
        .o_errors  (errors)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("** tagged_varint_codec: FAILED **");
            $finish;
        end
    end

    task automatic send_item(input logic [63:0] v, input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.value   <= v;
        in_ch.in_byte <= b;
        do @(negedge i_clk); while (in_ch.ready !== 1'b1);
        @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_coded(input logic [1:0] tag, input int nbytes);
        logic [7:0] lead;
        lead = {tag, 6'(($urandom_range(0, 63)))};
        send_item({$urandom, $urandom}, lead);
        for (int i = 1; i < nbytes; i++) begin
            send_item({$urandom, $urandom}, 8'($urandom));
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        in_ch.valid <= 1'b0;
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.mode  <= m;
        do @(negedge i_clk); while (cfg_ch.ready !== 1'b1);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // result side: per-result stall, with occasional stretches of none
    initial begin
        int stall;
        int served;
        served = 0;
        out_ch.ready = 1'b0;
        forever begin
            if (served % 16 == 0) begin
                out_burst = ($urandom_range(0, 3) == 0);
            end
            stall = out_burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(negedge i_clk); while (out_ch.valid !== 1'b1);
            @(posedge i_clk);
            served++;
        end
    end

    initial begin
        int          start_items;
        int          nseq;
        int          full_len;
        logic        m;
        logic [1:0]  tag;
        logic [63:0] v;

        cfg_ch.valid  = 1'b0;
        cfg_ch.mode   = MODE_ENCODE;
        in_ch.valid   = 1'b0;
        in_ch.value   = '0;
        in_ch.in_byte = '0;
        i_rst_n       = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (ENC_DIRECTED[i]) begin
            send_item(ENC_DIRECTED[i], 8'($urandom));
        end
        set_mode(MODE_DECODE);
        foreach (DEC_DIRECTED[i]) begin
            send_item({$urandom, $urandom}, DEC_DIRECTED[i]);
        end
        // rewrite must drop the partial value left above
        set_mode(MODE_DECODE);

        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if (items_sent != start_items) begin
                m = 1'($urandom_range(0, 1));
                set_mode(m);
            end else begin
                m = MODE_DECODE;
            end
            if (m == MODE_ENCODE) begin
                repeat ($urandom_range(8, 20)) begin
                    case ($urandom_range(0, 3))
                        0: v = 64'($urandom_range(0, 63));
                        1: v = 64'($urandom_range(64, 16383));
                        2: v = 64'($urandom_range(16384, 32'h3fff_ffff));
                        default: begin
                            v = {$urandom, $urandom};
                            if (v <= LIM_4B) begin
                                v[30] = 1'b1;
                            end
                        end
                    endcase
                    send_item(v, 8'($urandom));
                end
            end else begin
                nseq = $urandom_range(4, 10);
                repeat (nseq) begin
                    tag = 2'($urandom_range(0, 3));
                    case (tag)
                        TAG_1B:  full_len = 1;
                        TAG_2B:  full_len = 2;
                        TAG_4B:  full_len = 4;
                        default: full_len = 9;
                    endcase
                    if ($urandom_range(0, 3) != 0) begin
                        send_coded(tag, full_len);
                    end else begin
                        send_item({$urandom, $urandom}, 8'($urandom));
                    end
                end
                // leave an unfinished value behind for the next mode write
                if ($urandom_range(0, 1) == 1) begin
                    tag = 2'($urandom_range(1, 3));
                    full_len = (tag == TAG_2B) ? 2 : (tag == TAG_4B) ? 4 : 9;
                    send_coded(tag, $urandom_range(1, full_len - 1));
                end
            end
        end

        in_ch.valid <= 1'b0;
        wait_drained();
        @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("** tagged_varint_codec: PASSED **");
        end else begin
            $display("** tagged_varint_codec: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/vic_pkg.sv
hdl/vic_if.sv
hdl/vic_enc.sv
hdl/vic_dec.sv
hdl/tagged_varint_codec.sv
hdl/vic_checker.sv
dv/varint_checker.sv
dv/tb.sv
